### design/m2au_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2au_pkg
// Shared types, widths and helpers of the 2x2 matrix arithmetic unit.
// ----------------------------------------------------------------------------
package m2au_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // full product, product sum with sign headroom, quotient width
  localparam int PROD_W  = 2 * DATA_WIDTH;
  localparam int WIDE_W  = 2 * DATA_WIDTH + 2;
  localparam int QUO_W   = DATA_WIDTH + FRAC_BITS;

  // pipeline depth before the output register
  localparam int NSTAGE  = QUO_W + 6;

  // stream widths, rounded up to whole bytes
  localparam int IN_DATA_W  = ((11 * DATA_WIDTH + 7) / 8) * 8;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = ((4 * DATA_WIDTH + 3 + 7) / 8) * 8;

  typedef enum logic [3:0] {
    CMD_ADD       = 4'd0,
    CMD_SUB       = 4'd1,
    CMD_SCALE     = 4'd2,
    CMD_MATMUL    = 4'd3,
    CMD_DET       = 4'd4,
    CMD_INVERSE   = 4'd5,
    CMD_DIVIDE    = 4'd6,
    CMD_TRANSPOSE = 4'd7,
    CMD_NEGATE    = 4'd8,
    CMD_MATVEC    = 4'd9,
    CMD_EQUAL     = 4'd10
  } cmd_t;

  typedef logic signed [DATA_WIDTH-1:0] elem_t;
  typedef elem_t [3:0] mat_t;

  typedef struct packed {
    logic  ov;
    elem_t val;
  } sat_t;

  // per-stage item context carried along the pipeline
  typedef struct packed {
    cmd_t  cmd;
    mat_t  a;
    mat_t  b;
    elem_t s;
    elem_t vx;
    elem_t vy;
    mat_t  res;
    elem_t det;
    logic  ov;
    logic  sing;
    logic  det_ov;
    logic  eq;
  } side_t;

  // clamp a wide signed value to the element range
  function automatic sat_t sat_wide(input logic signed [WIDE_W-1:0] v);
    sat_t r;
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'($signed({1'b0, {(DATA_WIDTH-1){1'b1}}}));
    lo = WIDE_W'($signed({1'b1, {(DATA_WIDTH-1){1'b0}}}));
    if (v > hi) begin
      r.ov  = 1'b1;
      r.val = hi[DATA_WIDTH-1:0];
    end else if (v < lo) begin
      r.ov  = 1'b1;
      r.val = lo[DATA_WIDTH-1:0];
    end else begin
      r.ov  = 1'b0;
      r.val = v[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

### design/matrix2x2_arithmetic_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix2x2_arithmetic_unit_top
// 2x2 signed fixed-point matrix unit: four product lanes, four divider
// lanes for the inverse, four product lanes for inverse(A)*B, and a merge.
// ----------------------------------------------------------------------------
// Depth: the path from input transfer to output valid is dominated by the
//   48-stage divider pipeline of the inverse.
// Throughput: one item per cycle; the whole pipeline holds while a result
//   waits at the output.
// Reset: synchronous active-low rst_n clears the valid bits of every stage
//   and the output; payload registers are not reset.
module matrix2x2_arithmetic_unit_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // a00, a01, a10, a11, b00, b01, b10, b11, scale_factor, vec_x, vec_y
  input  logic [m2au_pkg::IN_DATA_W-1:0]   in_tdata,
  // command
  input  logic [m2au_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // r00, r01, r10, r11, singular, overflow, equal, zero fill
  output logic [m2au_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import m2au_pkg::*;

  localparam int ST_FRONT = 2;
  localparam int ST_QUO   = QUO_W + 2;
  localparam int ST_BACK  = QUO_W + 3;
  localparam int ST_LAST  = NSTAGE - 1;

  logic  en;
  side_t side_r   [NSTAGE];
  side_t side_nxt [NSTAGE];
  logic  vld_r    [NSTAGE];
  side_t front_nxt;
  side_t quo_nxt;

  elem_t fx1 [4], fy1 [4], fx2 [4], fy2 [4];
  logic  fneg [4];
  elem_t fres [4];
  logic  fov  [4];
  elem_t bres [4];
  logic  bov  [4];
  elem_t by1 [4], by2 [4], bx1 [4], bx2 [4];

  logic [QUO_W-1:0]      dnum [4];
  logic [QUO_W-1:0]      dquo [4];
  logic [DATA_WIDTH-1:0] ddvs;

  logic                  out_valid_r;
  mat_t                  out_res_r, out_res_nxt;
  logic                  out_sing_r, out_ov_r, out_eq_r, out_ov_nxt;

  // advance everything unless a result is held at the output
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // unpack the input transfer and apply the element-wise commands
  always_comb begin
    side_t s0;
    side_t s1;
    sat_t  sr;
    elem_t ai;
    elem_t bi;
    s0     = '0;
    s0.cmd = cmd_t'(in_tuser[3:0]);
    for (int i = 0; i < 4; i++) begin
      s0.a[i] = in_tdata[i*DATA_WIDTH +: DATA_WIDTH];
      s0.b[i] = in_tdata[(4+i)*DATA_WIDTH +: DATA_WIDTH];
    end
    s0.s  = in_tdata[8*DATA_WIDTH +: DATA_WIDTH];
    s0.vx = in_tdata[9*DATA_WIDTH +: DATA_WIDTH];
    s0.vy = in_tdata[10*DATA_WIDTH +: DATA_WIDTH];
    side_nxt[0] = s0;

    s1 = side_r[0];
    for (int i = 0; i < 4; i++) begin
      ai = side_r[0].a[i];
      bi = side_r[0].b[i];
      unique case (side_r[0].cmd)
        CMD_ADD:    sr = sat_wide(WIDE_W'(ai) + WIDE_W'(bi));
        CMD_SUB:    sr = sat_wide(WIDE_W'(ai) - WIDE_W'(bi));
        CMD_NEGATE: sr = sat_wide(-WIDE_W'(ai));
        default:    sr = '0;
      endcase
      s1.res[i] = sr.val;
      s1.ov     = s1.ov | sr.ov;
    end
    if (side_r[0].cmd == CMD_TRANSPOSE) begin
      s1.res[0] = side_r[0].a[0];
      s1.res[1] = side_r[0].a[2];
      s1.res[2] = side_r[0].a[1];
      s1.res[3] = side_r[0].a[3];
    end
    s1.eq = (side_r[0].cmd == CMD_EQUAL) && (side_r[0].a == side_r[0].b);
    side_nxt[1] = s1;

    for (int k = 2; k < NSTAGE; k++) begin
      side_nxt[k] = side_r[k-1];
    end
    side_nxt[ST_FRONT+1] = front_nxt;
    side_nxt[ST_QUO+1]   = quo_nxt;
  end

  // route operands to the front lanes per command
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      fx1[i]  = '0;
      fy1[i]  = '0;
      fx2[i]  = '0;
      fy2[i]  = '0;
      fneg[i] = 1'b0;
      unique case (side_r[0].cmd)
        CMD_SCALE: begin
          fx1[i] = side_r[0].a[i];
          fy1[i] = side_r[0].s;
        end
        CMD_MATMUL: begin
          fx1[i] = side_r[0].a[2*(i/2)];
          fy1[i] = side_r[0].b[i%2];
          fx2[i] = side_r[0].a[2*(i/2)+1];
          fy2[i] = side_r[0].b[2+(i%2)];
        end
        CMD_DET, CMD_INVERSE, CMD_DIVIDE: begin
          if (i == 0) begin
            fx1[i]  = side_r[0].a[0];
            fy1[i]  = side_r[0].a[3];
            fx2[i]  = side_r[0].a[1];
            fy2[i]  = side_r[0].a[2];
            fneg[i] = 1'b1;
          end
        end
        CMD_MATVEC: begin
          if (i < 2) begin
            fx1[i] = side_r[0].a[2*i];
            fy1[i] = side_r[0].vx;
            fx2[i] = side_r[0].a[2*i+1];
            fy2[i] = side_r[0].vy;
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_front
    m2au_lane u_lane (
      .clk  (clk),
      .en   (en),
      .x1   (fx1[i]),
      .y1   (fy1[i]),
      .x2   (fx2[i]),
      .y2   (fy2[i]),
      .neg2 (fneg[i]),
      .res  (fres[i]),
      .ov   (fov[i])
    );
  end

  // adjugate magnitudes over |det| into the divider lanes
  always_comb begin
    logic signed [DATA_WIDTH:0] adj [4];
    logic signed [DATA_WIDTH:0] dete;
    logic [DATA_WIDTH:0]        mag;
    adj[0] = (DATA_WIDTH+1)'(side_r[ST_FRONT].a[3]);
    adj[1] = -(DATA_WIDTH+1)'(side_r[ST_FRONT].a[1]);
    adj[2] = -(DATA_WIDTH+1)'(side_r[ST_FRONT].a[2]);
    adj[3] = (DATA_WIDTH+1)'(side_r[ST_FRONT].a[0]);
    for (int i = 0; i < 4; i++) begin
      mag     = adj[i][DATA_WIDTH] ? -adj[i] : adj[i];
      dnum[i] = {mag[DATA_WIDTH-1:0], {FRAC_BITS{1'b0}}};
    end
    dete = (DATA_WIDTH+1)'(fres[0]);
    mag  = dete[DATA_WIDTH] ? -dete : dete;
    ddvs = mag[DATA_WIDTH-1:0];
  end

  for (genvar i = 0; i < 4; i++) begin : g_div
    m2au_div u_div (
      .clk (clk),
      .en  (en),
      .num (dnum[i]),
      .dvs (ddvs),
      .quo (dquo[i])
    );
  end

  // back lanes: inverse times B
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      bx1[i] = side_r[ST_BACK].res[2*(i/2)];
      by1[i] = side_r[ST_BACK].b[i%2];
      bx2[i] = side_r[ST_BACK].res[2*(i/2)+1];
      by2[i] = side_r[ST_BACK].b[2+(i%2)];
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_back
    m2au_lane u_lane (
      .clk  (clk),
      .en   (en),
      .x1   (bx1[i]),
      .y1   (by1[i]),
      .x2   (bx2[i]),
      .y2   (by2[i]),
      .neg2 (1'b0),
      .res  (bres[i]),
      .ov   (bov[i])
    );
  end

  // merge front lane results, then the signed quotients
  always_comb begin
    side_t sf;
    side_t sq;
    logic  neg;
    logic  adjn [4];
    logic signed [WIDE_W-1:0] qv;
    sat_t  tr;
    logic  tov;
    sf = side_r[ST_FRONT];
    unique case (side_r[ST_FRONT].cmd)
      CMD_SCALE, CMD_MATMUL, CMD_DET, CMD_MATVEC: begin
        for (int i = 0; i < 4; i++) begin
          sf.res[i] = fres[i];
        end
        sf.ov = fov[0] | fov[1] | fov[2] | fov[3];
      end
      CMD_INVERSE, CMD_DIVIDE: begin
        sf.det    = fres[0];
        sf.det_ov = fov[0];
        sf.sing   = (fres[0] == '0);
      end
      default: ;
    endcase

    sq      = side_r[ST_QUO];
    adjn[0] = side_r[ST_QUO].a[3][DATA_WIDTH-1];
    adjn[1] = (side_r[ST_QUO].a[1] > 0);
    adjn[2] = (side_r[ST_QUO].a[2] > 0);
    adjn[3] = side_r[ST_QUO].a[0][DATA_WIDTH-1];
    tov     = side_r[ST_QUO].det_ov;
    for (int i = 0; i < 4; i++) begin
      neg = adjn[i] ^ side_r[ST_QUO].det[DATA_WIDTH-1];
      qv  = $signed({{(WIDE_W-QUO_W){1'b0}}, dquo[i]});
      tr  = sat_wide(neg ? -qv : qv);
      if ((side_r[ST_QUO].cmd == CMD_INVERSE) || (side_r[ST_QUO].cmd == CMD_DIVIDE)) begin
        sq.res[i] = side_r[ST_QUO].sing ? '0 : tr.val;
      end
      tov = tov | tr.ov;
    end
    if ((side_r[ST_QUO].cmd == CMD_INVERSE) || (side_r[ST_QUO].cmd == CMD_DIVIDE)) begin
      sq.ov = side_r[ST_QUO].sing ? 1'b0 : tov;
    end

    front_nxt = sf;
    quo_nxt   = sq;
  end

  // pick the final result for the output register
  always_comb begin
    out_res_nxt = side_r[ST_LAST].res;
    out_ov_nxt  = side_r[ST_LAST].ov;
    if ((side_r[ST_LAST].cmd == CMD_DIVIDE) && !side_r[ST_LAST].sing) begin
      for (int i = 0; i < 4; i++) begin
        out_res_nxt[i] = bres[i];
      end
      out_ov_nxt = side_r[ST_LAST].ov | bov[0] | bov[1] | bov[2] | bov[3];
    end
  end

  // hold state, advance the valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTAGE; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k < NSTAGE; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_valid_r <= vld_r[ST_LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NSTAGE; k++) begin
        side_r[k] <= side_nxt[k];
      end
      out_res_r  <= out_res_nxt;
      out_ov_r   <= out_ov_nxt;
      out_sing_r <= side_r[ST_LAST].sing &&
                    ((side_r[ST_LAST].cmd == CMD_INVERSE) ||
                     (side_r[ST_LAST].cmd == CMD_DIVIDE));
      out_eq_r   <= side_r[ST_LAST].eq;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_eq_r, out_ov_r, out_sing_r,
                                   out_res_r[3], out_res_r[2],
                                   out_res_r[1], out_res_r[0]});

  // a singular result carries zeros and no overflow
  a_sing_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sing_r |-> !out_ov_r && (out_res_r == '0))
    else $error("singular result not cleared");

  // equality leaves every other field at zero
  a_eq_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_eq_r |-> !out_sing_r && !out_ov_r && (out_res_r == '0))
    else $error("equal result carries other fields");

  // an accepted transfer enters the first stage
  a_in_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted transfer lost at pipeline entry");

  // a stall freezes the last stage
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r[ST_LAST]))
    else $error("pipeline moved during stall");

endmodule

### design/m2au_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2au_lane
// Two-stage dot-product lane: x1*y1 +/- x2*y2, floored to the fraction
// point and saturated.
// ----------------------------------------------------------------------------
module m2au_lane (
  input  logic              clk,
  input  logic              en,
  input  m2au_pkg::elem_t   x1,
  input  m2au_pkg::elem_t   y1,
  input  m2au_pkg::elem_t   x2,
  input  m2au_pkg::elem_t   y2,
  input  logic              neg2,
  output m2au_pkg::elem_t   res,
  output logic              ov
);
  import m2au_pkg::*;

  logic signed [PROD_W-1:0] p1_r, p1_nxt;
  logic signed [PROD_W:0]   p2_r, p2_nxt;
  logic signed [PROD_W-1:0] prod2;
  logic signed [PROD_W:0]   p2e;
  logic signed [WIDE_W-1:0] sum;
  logic signed [WIDE_W-1:0] shr;
  sat_t                     st;
  elem_t                    res_r;
  logic                     ov_r;

  // form both products, negate the second on request
  always_comb begin
    p1_nxt = x1 * y1;
    prod2  = x2 * y2;
    p2e    = (PROD_W+1)'(prod2);
    p2_nxt = neg2 ? -p2e : p2e;
  end

  // add exactly, floor to the fraction point, clamp
  always_comb begin
    sum = WIDE_W'(p1_r) + WIDE_W'(p2_r);
    shr = sum >>> FRAC_BITS;
    st  = sat_wide(shr);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= p1_nxt;
      p2_r  <= p2_nxt;
      res_r <= st.val;
      ov_r  <= st.ov;
    end
  end

  assign res = res_r;
  assign ov  = ov_r;

endmodule

### design/m2au_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2au_div
// Pipelined restoring divider for unsigned magnitudes, one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module m2au_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic [m2au_pkg::QUO_W-1:0]     num,
  input  logic [m2au_pkg::DATA_WIDTH-1:0] dvs,
  output logic [m2au_pkg::QUO_W-1:0]     quo
);
  import m2au_pkg::*;

  localparam int ACC_W = DATA_WIDTH + QUO_W;

  logic [ACC_W-1:0]      acc_r   [QUO_W];
  logic [ACC_W-1:0]      acc_nxt [QUO_W];
  logic [DATA_WIDTH-1:0] dvs_r   [QUO_W];
  logic [DATA_WIDTH-1:0] dvs_src [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    logic [ACC_W-1:0]      src;
    logic [DATA_WIDTH:0]   top;
    logic [DATA_WIDTH:0]   diff;
    logic                  ge;

    // pick the previous stage, or the fresh operands at the head
    if (i == 0) begin : g_head
      assign src        = {{DATA_WIDTH{1'b0}}, num};
      assign dvs_src[i] = dvs;
    end else begin : g_body
      assign src        = acc_r[i-1];
      assign dvs_src[i] = dvs_r[i-1];
    end

    // shift in one numerator bit, subtract when it fits
    always_comb begin
      top        = src[ACC_W-1:QUO_W-1];
      ge         = top >= {1'b0, dvs_src[i]};
      diff       = top - {1'b0, dvs_src[i]};
      acc_nxt[i] = {(ge ? diff[DATA_WIDTH-1:0] : top[DATA_WIDTH-1:0]),
                    src[QUO_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[i] <= acc_nxt[i];
        dvs_r[i] <= dvs_src[i];
      end
    end
  end

  assign quo = acc_r[QUO_W-1][QUO_W-1:0];

endmodule
